### sv/uti_pkg.sv
`timescale 1ns / 1ps
// uti_pkg: shared types, register codes and constants of the unicycle trajectory integrator
// used by uti_cordic, uti_seq and unicycle_trajectory_integrator; depends on nothing

package uti_pkg;

  // widths of the pose, count, config port and config register fields
  localparam int POS_W   = 32;
  localparam int HEAD_W  = 16;
  localparam int CNT_W   = 7;
  localparam int IDX_W   = 6;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int RATE_W  = 24;
  localparam int STEP_W  = 16;

  // config register codes (paddr[3:2])
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_SPEED = 2'd1;
  localparam logic [1:0] REG_RATE  = 2'd2;
  localparam logic [1:0] REG_STEP  = 2'd3;

  // rotator constants: 28 iterations, Q2.30 gain, atan in 2^-32 turn units
  localparam int CORDIC_STAGES = 28;
  localparam int CORDIC_IDX_W  = 5;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [29:0] ATAN_TAB [CORDIC_STAGES] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465,  30'd10680862,  30'd5340245,   30'd2670163,  30'd1335087,
    30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
    30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
    30'd20,        30'd10,        30'd5
  };

  // configuration bundle
  typedef struct packed {
    logic                      mode;
    logic signed [POS_W-1:0]   speed;
    logic signed [RATE_W-1:0]  rate;
    logic [STEP_W-1:0]         step;
  } uti_cfg_t;

  // request to the rotator
  typedef struct packed {
    logic              start;
    logic [HEAD_W-1:0] angle;
  } crd_req_t;

  typedef enum logic [1:0] {
    CRD_IDLE,
    CRD_ROT,
    CRD_FIN
  } crd_state_t;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_MUL_DIST,
    SEQ_MUL_TURN,
    SEQ_CAP_TURN,
    SEQ_EMIT,
    SEQ_ROT,
    SEQ_MUL_X,
    SEQ_MUL_Y,
    SEQ_CAP_Y
  } seq_state_t;

  // clamp a widened position sum to the signed 32 bit range
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
    logic signed [POS_W-1:0] res;
    if (v[POS_W+1:POS_W-1] == 3'b000 || v[POS_W+1:POS_W-1] == 3'b111) begin
      res = v[POS_W-1:0];
    end else if (v[POS_W+1]) begin
      res = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(POS_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

### sv/uti_mul.sv
`timescale 1ns / 1ps
// uti_mul: shared signed multiplier with a registered product
// no package dependency

module uti_mul #(
  parameter int A_W = 32,
  parameter int B_W = 17
) (
  input  logic                     clk,
  input  logic signed [A_W-1:0]    mul_a,
  input  logic signed [B_W-1:0]    mul_b,
  output logic signed [A_W+B_W-1:0] mul_p
);

  logic signed [A_W+B_W-1:0] prod_r;

  // one product per cycle, registered so the result appears in the next cycle
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign mul_p = prod_r;

endmodule

### sv/uti_cordic.sv
`timescale 1ns / 1ps
// uti_cordic: iterative rotation-mode CORDIC, one micro-rotation per cycle
// depends on uti_pkg (angle table, gain, state type, request struct)

module uti_cordic
  import uti_pkg::*;
#(
  parameter int TRIG_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  crd_req_t                    req,
  output logic                        done,
  output logic signed [TRIG_BITS-1:0] cos_val,
  output logic signed [TRIG_BITS-1:0] sin_val
);

  localparam int SH = 31 - TRIG_BITS;
  localparam logic signed [33:0] RND     = 34'sd1 <<< (SH - 1);
  localparam logic signed [33:0] TRIG_HI = (34'sd1 <<< (TRIG_BITS - 1)) - 34'sd1;
  localparam logic signed [33:0] TRIG_LO = -(34'sd1 <<< (TRIG_BITS - 1));

  crd_state_t state_r, state_nxt;

  logic signed [33:0]      x_r, y_r;
  logic signed [31:0]      z_r;
  logic [CORDIC_IDX_W-1:0] i_r;
  logic [1:0]              quad_r;
  logic signed [TRIG_BITS-1:0] cos_r, sin_r;
  logic                    done_r;

  logic signed [33:0] shx, shy, rot_x, rot_y;
  logic signed [31:0] atan_v, rot_z;
  logic signed [33:0] cq, sq, rc, rs;

  function automatic logic signed [TRIG_BITS-1:0] clamp_trig(input logic signed [33:0] v);
    logic signed [TRIG_BITS-1:0] res;
    if (v > TRIG_HI) begin
      res = TRIG_HI[TRIG_BITS-1:0];
    end else if (v < TRIG_LO) begin
      res = TRIG_LO[TRIG_BITS-1:0];
    end else begin
      res = v[TRIG_BITS-1:0];
    end
    return res;
  endfunction

  // one micro-rotation, direction from the sign of the residual angle
  always_comb begin
    shx    = x_r >>> i_r;
    shy    = y_r >>> i_r;
    atan_v = {2'b00, ATAN_TAB[i_r]};
    if (z_r[31]) begin
      rot_x = x_r + shy;
      rot_y = y_r - shx;
      rot_z = z_r + atan_v;
    end else begin
      rot_x = x_r - shy;
      rot_y = y_r + shx;
      rot_z = z_r - atan_v;
    end
  end

  // quadrant unfold and rounding to the output format
  always_comb begin
    unique case (quad_r)
      2'd0: begin cq = x_r;  sq = y_r;  end
      2'd1: begin cq = -y_r; sq = x_r;  end
      2'd2: begin cq = -x_r; sq = -y_r; end
      default: begin cq = y_r; sq = -x_r; end
    endcase
    rc = (cq + RND) >>> SH;
    rs = (sq + RND) >>> SH;
  end

  // sequencer of the iterations
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CRD_IDLE: if (req.start) state_nxt = CRD_ROT;
      CRD_ROT:  if (i_r == CORDIC_IDX_W'(CORDIC_STAGES - 1)) state_nxt = CRD_FIN;
      CRD_FIN:  state_nxt = CRD_IDLE;
      default:  state_nxt = CRD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CRD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == CRD_FIN);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      CRD_IDLE: begin
        x_r    <= CORDIC_GAIN;
        y_r    <= '0;
        z_r    <= {2'b00, req.angle[13:0], 16'h0000};
        quad_r <= req.angle[15:14];
        i_r    <= '0;
      end
      CRD_ROT: begin
        x_r <= rot_x;
        y_r <= rot_y;
        z_r <= rot_z;
        i_r <= i_r + CORDIC_IDX_W'(1);
      end
      CRD_FIN: begin
        cos_r <= clamp_trig(rc);
        sin_r <= clamp_trig(rs);
      end
      default: begin
        i_r <= '0;
      end
    endcase
  end

  assign done    = done_r;
  assign cos_val = cos_r;
  assign sin_val = sin_r;

endmodule

### sv/uti_seq.sv
`timescale 1ns / 1ps
// uti_seq: run sequencer, pose registers and output word register
// depends on uti_pkg; drives the shared multiplier and the rotator

module uti_seq
  import uti_pkg::*;
#(
  parameter int TRIG_BITS   = 16,
  parameter int MUL_B_W     = 17,
  parameter int POINT_LIMIT = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  uti_cfg_t                      cfg,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [POS_W-1:0]       in_start_x,
  input  logic signed [POS_W-1:0]       in_start_y,
  input  logic [HEAD_W-1:0]             in_start_heading,
  input  logic [CNT_W-1:0]              in_point_count,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [POS_W-1:0]       out_pose_x,
  output logic signed [POS_W-1:0]       out_pose_y,
  output logic [HEAD_W-1:0]             out_pose_heading,
  output logic [IDX_W-1:0]              out_pose_index,
  output logic                          out_last_pose,
  // rotator
  output crd_req_t                      crd_req,
  input  logic                          crd_done,
  input  logic signed [TRIG_BITS-1:0]   crd_cos,
  input  logic signed [TRIG_BITS-1:0]   crd_sin,
  // shared multiplier
  output logic signed [POS_W-1:0]       mul_a,
  output logic signed [MUL_B_W-1:0]     mul_b,
  input  logic signed [POS_W+MUL_B_W-1:0] mul_p
);

  localparam int P_W = POS_W + MUL_B_W;
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(POINT_LIMIT);

  seq_state_t state_r, state_nxt;

  logic signed [POS_W-1:0] cur_x_r, cur_y_r, dist_r;
  logic [HEAD_W-1:0]       head_r, dhead_r, half_r;
  logic [CNT_W-1:0]        n_r;
  logic [IDX_W-1:0]        k_r;

  logic                    out_valid_r, out_last_r;
  logic signed [POS_W-1:0] out_x_r, out_y_r;
  logic [HEAD_W-1:0]       out_head_r;
  logic [IDX_W-1:0]        out_idx_r;

  logic                    out_free, is_last, emit_load;
  logic [CNT_W-1:0]        sat_count;
  logic [P_W-1:0]          sum_q16, sum_q17, sum_pos;
  logic signed [POS_W+1:0] inc_w, base_w, pos_w;
  logic signed [POS_W-1:0] pos_base, pos_new;

  assign out_free  = !out_valid_r || !out_stall;
  assign is_last   = ({1'b0, k_r} + CNT_W'(1)) == n_r;
  assign sat_count = (in_point_count > LIMIT) ? LIMIT : in_point_count;
  assign in_stall  = (state_r != SEQ_IDLE);

  // operand selection for the shared multiplier
  always_comb begin
    unique case (state_r)
      SEQ_MUL_DIST: begin
        mul_a = cfg.speed;
        mul_b = MUL_B_W'(cfg.step);
      end
      SEQ_MUL_TURN: begin
        mul_a = POS_W'(cfg.rate);
        mul_b = MUL_B_W'(cfg.step);
      end
      SEQ_MUL_X: begin
        mul_a = dist_r;
        mul_b = MUL_B_W'(crd_cos);
      end
      SEQ_MUL_Y: begin
        mul_a = dist_r;
        mul_b = MUL_B_W'(crd_sin);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // rounding of the registered products
  always_comb begin
    sum_q16  = mul_p + (P_W'(1) << 15);
    sum_q17  = mul_p + (P_W'(1) << 16);
    sum_pos  = mul_p + (P_W'(1) << (TRIG_BITS - 2));
    inc_w    = sum_pos[TRIG_BITS+POS_W:TRIG_BITS-1];
    pos_base = (state_r == SEQ_CAP_Y) ? cur_y_r : cur_x_r;
    base_w   = (POS_W+2)'(pos_base);
    pos_w    = base_w + inc_w;
    pos_new  = sat_pos(pos_w);
  end

  // next state and strobes
  always_comb begin
    state_nxt     = state_r;
    emit_load     = 1'b0;
    crd_req.start = 1'b0;
    crd_req.angle = head_r + (cfg.mode ? half_r : HEAD_W'(0));
    unique case (state_r)
      SEQ_IDLE:     if (in_valid && in_point_count != '0) state_nxt = SEQ_MUL_DIST;
      SEQ_MUL_DIST: state_nxt = SEQ_MUL_TURN;
      SEQ_MUL_TURN: state_nxt = SEQ_CAP_TURN;
      SEQ_CAP_TURN: state_nxt = SEQ_EMIT;
      SEQ_EMIT: begin
        if (out_free) begin
          emit_load = 1'b1;
          if (is_last) begin
            state_nxt = SEQ_IDLE;
          end else begin
            crd_req.start = 1'b1;
            state_nxt     = SEQ_ROT;
          end
        end
      end
      SEQ_ROT:      if (crd_done) state_nxt = SEQ_MUL_X;
      SEQ_MUL_X:    state_nxt = SEQ_MUL_Y;
      SEQ_MUL_Y:    state_nxt = SEQ_CAP_Y;
      SEQ_CAP_Y:    state_nxt = SEQ_EMIT;
      default:      state_nxt = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // pose and step registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      SEQ_IDLE: begin
        if (in_valid) begin
          cur_x_r <= in_start_x;
          cur_y_r <= in_start_y;
          head_r  <= in_start_heading;
          n_r     <= sat_count;
          k_r     <= '0;
        end
      end
      SEQ_MUL_TURN: dist_r <= sum_q16[POS_W+15:16];
      SEQ_CAP_TURN: begin
        dhead_r <= sum_q16[HEAD_W+15:16];
        half_r  <= sum_q17[HEAD_W+16:17];
      end
      SEQ_MUL_Y: cur_x_r <= pos_new;
      SEQ_CAP_Y: begin
        cur_y_r <= pos_new;
        head_r  <= head_r + dhead_r;
        k_r     <= k_r + IDX_W'(1);
      end
      default: begin
        n_r <= n_r;
      end
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_x_r    <= cur_x_r;
      out_y_r    <= cur_y_r;
      out_head_r <= head_r;
      out_idx_r  <= k_r;
      out_last_r <= is_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pose_x       = out_x_r;
  assign out_pose_y       = out_y_r;
  assign out_pose_heading = out_head_r;
  assign out_pose_index   = out_idx_r;
  assign out_last_pose    = out_last_r;

endmodule

### sv/unicycle_trajectory_integrator.sv
`timescale 1ns / 1ps
// unicycle_trajectory_integrator: top level, config registers and block wiring
// depends on uti_pkg, uti_mul, uti_cordic and uti_seq
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_stall    | start_x, start_y, start_heading, point_count
//   out_    | output    | out_valid / out_stall  | pose_x, pose_y, pose_heading, pose_index,
//           |           |                        | last_pose
//   config  | APB       | psel, penable, pready  | paddr, pwdata, prdata
//
// a word runs the distance and turn multiplies, a capture and the first emit; each later pose step
// is the rotator (28 iterations, unfold, done) plus two multiplies, a capture, the emit
// in_stall is high from the cycle after acceptance until the last pose is in the output
// register; the next word can be taken while that pose still waits on out_stall
// out_stall holds the sequencer at the next pose only; reset is synchronous, active low

module unicycle_trajectory_integrator
  import uti_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int TRIG_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // config port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [POS_W-1:0]   in_start_x,
  input  logic signed [POS_W-1:0]   in_start_y,
  input  logic [HEAD_W-1:0]         in_start_heading,
  input  logic [CNT_W-1:0]          in_point_count,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [POS_W-1:0]   out_pose_x,
  output logic signed [POS_W-1:0]   out_pose_y,
  output logic [HEAD_W-1:0]         out_pose_heading,
  output logic [IDX_W-1:0]          out_pose_index,
  output logic                      out_last_pose
);

  localparam int POINT_LIMIT = (MAX_POINTS < 64) ? MAX_POINTS : 64;
  localparam int MUL_B_W     = ((TRIG_BITS > 16) ? TRIG_BITS : 16) + 1;

  uti_cfg_t   cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  crd_req_t                     crd_req;
  logic                         crd_done;
  logic signed [TRIG_BITS-1:0]  crd_cos, crd_sin;
  logic signed [POS_W-1:0]      mul_a;
  logic signed [MUL_B_W-1:0]    mul_b;
  logic signed [POS_W+MUL_B_W-1:0] mul_p;

  // config write decode
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:  cfg_r.mode  <= pwdata[0];
        REG_SPEED: cfg_r.speed <= pwdata;
        REG_RATE:  cfg_r.rate  <= pwdata[RATE_W-1:0];
        REG_STEP:  cfg_r.step  <= pwdata[STEP_W-1:0];
        default:   cfg_r       <= cfg_r;
      endcase
    end
  end

  // config read mux
  always_comb begin
    unique case (reg_idx)
      REG_MODE:  prdata = DATA_W'(cfg_r.mode);
      REG_SPEED: prdata = cfg_r.speed;
      REG_RATE:  prdata = {{(DATA_W-RATE_W){1'b0}}, cfg_r.rate};
      REG_STEP:  prdata = {{(DATA_W-STEP_W){1'b0}}, cfg_r.step};
      default:   prdata = '0;
    endcase
  end

  uti_seq #(
    .TRIG_BITS   (TRIG_BITS),
    .MUL_B_W     (MUL_B_W),
    .POINT_LIMIT (POINT_LIMIT)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_start_heading (in_start_heading),
    .in_point_count   (in_point_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pose_x       (out_pose_x),
    .out_pose_y       (out_pose_y),
    .out_pose_heading (out_pose_heading),
    .out_pose_index   (out_pose_index),
    .out_last_pose    (out_last_pose),
    .crd_req          (crd_req),
    .crd_done         (crd_done),
    .crd_cos          (crd_cos),
    .crd_sin          (crd_sin),
    .mul_a            (mul_a),
    .mul_b            (mul_b),
    .mul_p            (mul_p)
  );

  uti_cordic #(
    .TRIG_BITS (TRIG_BITS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (crd_req),
    .done    (crd_done),
    .cos_val (crd_cos),
    .sin_val (crd_sin)
  );

  uti_mul #(
    .A_W (POS_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

`ifndef ASSERT_OFF
  // a run with poses keeps the input side busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_point_count != '0 |=> in_stall)
    else $error("input not stalled after starting a run");

  // when idle, a pending word can only be the last pose of a run
  a_idle_last_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && out_valid |-> out_last_pose)
    else $error("idle with a non-final pose pending");

  // the rotator only finishes inside a run
  a_cordic_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    crd_done |-> in_stall)
    else $error("rotator finished outside a run");
`endif

endmodule
